// ===== rtl/bmp_pkg.sv =====
// bmp_pkg: shared types, codes and constants for the banked memory pager
// used by bmp_xlate and banked_memory_pager_with_dos_trap
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bmp_pkg;

  // default number of physical ram pages
  localparam int RAM_PAGE_COUNT_DEF = 8;

  // field widths
  localparam int OP_W     = 3;
  localparam int ADDR_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int TGT_W    = 3;
  localparam int ROM_W    = 2;
  localparam int PAGE_W   = 3;
  localparam int OFFS_W   = 14;

  // stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // decode constants
  localparam logic [ADDR_W-1:0] PORT_DECODE_MASK = 16'h8002;
  localparam logic [7:0]        TRAP_PAGE_HI     = 8'h3D;
  localparam int                ROM48_BIT        = 4;
  localparam logic [PAGE_W-1:0] SLOT1_PAGE       = 3'd5;
  localparam logic [PAGE_W-1:0] SLOT2_PAGE       = 3'd2;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_FETCH = 3'd2,
    OP_PORT  = 3'd3,
    OP_TRAP  = 3'd4
  } opcode_t;

  typedef enum logic [TGT_W-1:0] {
    TGT_ROM     = 3'd0,
    TGT_RAM     = 3'd1,
    TGT_DISCARD = 3'd2,
    TGT_TRAP    = 3'd3,
    TGT_NONE    = 3'd4
  } target_t;

  typedef enum logic [ROM_W-1:0] {
    ROM_128 = 2'd0,
    ROM_48  = 2'd1,
    ROM_DOS = 2'd2
  } rom_t;

  typedef enum logic [1:0] {
    SLOT_ROM   = 2'd0,
    SLOT_RAM5  = 2'd1,
    SLOT_RAM2  = 2'd2,
    SLOT_PAGED = 2'd3
  } slot_t;

  // paging state
  typedef struct packed {
    logic [BYTE_W-1:0] port_value;
    rom_t              rom_select;
    logic              dos_active;
  } pager_state_t;

  // one translated access
  typedef struct packed {
    target_t           target;
    logic [ROM_W-1:0]  rom_id;
    logic [PAGE_W-1:0] ram_page;
    logic [OFFS_W-1:0] page_offset;
    logic              port_hit;
    logic              trap_switched;
  } xlate_result_t;

endpackage

`default_nettype wire

// ===== rtl/bmp_xlate.sv =====
// bmp_xlate: combinational address translation and paging state update
// depends on bmp_pkg
`timescale 1ns / 1ps
`default_nettype none

module bmp_xlate
  import bmp_pkg::*;
#(
  parameter int RAM_PAGE_COUNT = RAM_PAGE_COUNT_DEF
) (
  input  wire opcode_t           opcode,
  input  wire logic [ADDR_W-1:0] address,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire pager_state_t      state_cur,
  output pager_state_t           state_nxt,
  output xlate_result_t          result
);

  localparam int PageIdxW = $clog2(RAM_PAGE_COUNT);

  slot_t slot;
  logic  trap_page;

  assign slot      = slot_t'(address[ADDR_W-1:ADDR_W-2]);
  assign trap_page = (address[ADDR_W-1:ADDR_W-8] == TRAP_PAGE_HI);

  always_comb begin
    result    = '0;
    result.target = TGT_NONE;
    state_nxt = state_cur;
    unique case (opcode)
      OP_READ, OP_WRITE, OP_FETCH: begin
        result.page_offset = address[OFFS_W-1:0];
        if (slot == SLOT_ROM) begin
          if (opcode == OP_WRITE) begin
            result.target = TGT_DISCARD;
          end else if (opcode == OP_FETCH && state_cur.rom_select == ROM_48 && trap_page) begin
            result.target = TGT_TRAP;
          end else begin
            result.target = TGT_ROM;
            result.rom_id = state_cur.rom_select;
          end
        end else if (opcode == OP_FETCH && state_cur.dos_active) begin
          // dos runs only from rom, fetches outside it are trapped
          result.target = TGT_TRAP;
        end else begin
          result.target = TGT_RAM;
          unique case (slot)
            SLOT_RAM5: result.ram_page = SLOT1_PAGE;
            SLOT_RAM2: result.ram_page = SLOT2_PAGE;
            default:   result.ram_page =
                         PAGE_W'({1'b0, state_cur.port_value[PageIdxW-1:0]});
          endcase
        end
      end
      OP_PORT: begin
        if ((address & PORT_DECODE_MASK) == '0) begin
          result.port_hit      = 1'b1;
          state_nxt.port_value = data_byte;
          state_nxt.rom_select = data_byte[ROM48_BIT] ? ROM_48 : ROM_128;
          state_nxt.dos_active = 1'b0;
        end
      end
      OP_TRAP: begin
        if (state_cur.rom_select == ROM_48 && trap_page) begin
          state_nxt.rom_select = ROM_DOS;
          state_nxt.dos_active = 1'b1;
          result.trap_switched = 1'b1;
        end else if (state_cur.rom_select == ROM_DOS && slot != SLOT_ROM) begin
          state_nxt.rom_select = ROM_48;
          state_nxt.dos_active = 1'b0;
          result.trap_switched = 1'b1;
        end
      end
      default: begin
        // unused opcodes leave everything as is
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/banked_memory_pager_with_dos_trap.sv =====
// banked_memory_pager_with_dos_trap: top level of the 128k pager with dos trap
// depends on bmp_pkg and bmp_xlate
//
// channel  dir  handshake               payload
// in_      in   in_tvalid / in_tready   tuser: opcode; tdata: address, data_byte
// out_     out  out_tvalid / out_tready tuser: target; tdata: rom_id .. trap_switched
// cfg_     in   cfg_tvalid / cfg_tready tdata: boot_rom
//
// one access is taken per cycle while out_ does not stall; a result passes the input register,
// then the result register, before it is presented; throughput is set by the single translate
// stage, which reads and updates the paging state
// reset (rst_n low at a clock edge) loads the 128k rom, clears the port value and dos;
// in_tready and cfg_tready stay low while rst_n is low
// a boot_rom write reloads the same state with the chosen rom (3 acts as 2)
// a stall on out_ holds the result register; the input register keeps taking a
// transfer whenever it is empty or moves on in the same cycle
`timescale 1ns / 1ps
`default_nettype none

module banked_memory_pager_with_dos_trap
  import bmp_pkg::*;
#(
  parameter int RAM_PAGE_COUNT = RAM_PAGE_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // config
  input  wire logic                  cfg_tvalid,
  output logic                       cfg_tready,
  input  wire logic [ROM_W-1:0]      cfg_tdata,   // [1:0] boot_rom
  // access stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [OP_W-1:0]       in_tuser,    // [2:0] opcode
  input  wire logic [IN_DATA_W-1:0]  in_tdata,    // [15:0] address, [23:16] data_byte
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [TGT_W-1:0]           out_tuser,   // [2:0] target
  output logic [OUT_DATA_W-1:0]      out_tdata    // [1:0] rom_id, [4:2] ram_page,
                                                  // [18:5] page_offset, [19] port_hit,
                                                  // [20] trap_switched, [23:21] zero
);

  // input register
  logic                s1_valid_r;
  logic [OP_W-1:0]     s1_op_r;
  logic [ADDR_W-1:0]   s1_addr_r;
  logic [BYTE_W-1:0]   s1_byte_r;
  logic                s1_advance;

  // result register
  logic                out_valid_r;
  xlate_result_t       out_res_r;

  // paging state
  pager_state_t        state_r;
  pager_state_t        state_nxt;
  xlate_result_t       res_nxt;

  // state loaded at reset or on a boot_rom write
  pager_state_t        boot_state;
  rom_t                boot_rom;

  // no transfer is taken while reset is held
  assign cfg_tready = rst_n;

  // a value of 3 saturates to the dos rom
  assign boot_rom = (cfg_tdata > ROM_W'(ROM_DOS)) ? ROM_DOS : rom_t'(cfg_tdata);
  always_comb begin
    boot_state            = '0;
    boot_state.rom_select = boot_rom;
    boot_state.dos_active = (boot_rom == ROM_DOS);
  end

  // the input stage moves on when the result register is free or being drained
  assign s1_advance = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = rst_n && (!s1_valid_r || s1_advance);

  bmp_xlate #(
    .RAM_PAGE_COUNT (RAM_PAGE_COUNT)
  ) u_xlate (
    .opcode    (opcode_t'(s1_op_r)),
    .address   (s1_addr_r),
    .data_byte (s1_byte_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  // input register: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // input register: payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tuser;
      s1_addr_r <= in_tdata[ADDR_W-1:0];
      s1_byte_r <= in_tdata[ADDR_W+BYTE_W-1:ADDR_W];
    end
  end

  // paging state, updated as each access leaves the input stage unless a boot_rom write reloads it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{port_value: '0, rom_select: ROM_128, dos_active: 1'b0};
    end else if (cfg_tvalid && cfg_tready) begin
      state_r <= boot_state;
    end else if (s1_advance) begin
      state_r <= state_nxt;
    end
  end

  // result register: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register: payload
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.target;
  assign out_tdata  = {3'b000, out_res_r.trap_switched, out_res_r.port_hit,
                       out_res_r.page_offset, out_res_r.ram_page, out_res_r.rom_id};

  // dos mode and the dos rom always go together
  a_dos_matches_rom: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.dos_active == (state_r.rom_select == ROM_DOS))
    else $error("dos flag out of step with rom select");

  // the rom select never takes the unused code
  a_rom_select_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.rom_select == ROM_128 || state_r.rom_select == ROM_48 ||
    state_r.rom_select == ROM_DOS)
    else $error("rom select holds an unused code");

  // the input stage never overwrites a result that is still stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance |-> (!out_valid_r || out_tready))
    else $error("result register overrun");

  // port and trap flags only come with accesses that touch no memory
  a_flags_no_mem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.port_hit || out_res_r.trap_switched))
      |-> out_res_r.target == TGT_NONE)
    else $error("flag raised on a memory access");

  // a trap-check switch flips the dos mode
  a_switch_flips_dos: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && res_nxt.trap_switched && !(cfg_tvalid && cfg_tready))
      |=> state_r.dos_active != $past(state_r.dos_active))
    else $error("trap switch did not change dos mode");

endmodule

`default_nettype wire
